// ----- rtl/sfir_pkg.sv -----
// ----------------------------------------------------------------------------
// sfir_pkg - stereo FIR muffle shared definitions
// Sizes, arithmetic constants, register indexes and the coefficient profile.
// ----------------------------------------------------------------------------
package sfir_pkg;

    localparam int MAX_TAPS   = 512;
    localparam int SAMPLE_W   = 32;
    localparam int IDX_W      = $clog2(MAX_TAPS);
    localparam int TAPS_W     = $clog2(MAX_TAPS + 1);

    localparam int TAP_CFG_W  = 10;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_ADDR_W = 2;

    // coefficients, unsigned Q0.20
    localparam int COEF_W     = 15;
    localparam int COEF_FLAT  = 20971;
    localparam int COEF_FRAC  = 20;
    localparam int FLAT_END   = (MAX_TAPS * 55) / 100;
    localparam int FADE_END   = (MAX_TAPS * 64) / 100;
    localparam int FADE_N     = FADE_END - FLAT_END;
    localparam int FADE_IW    = (FADE_N > 1) ? $clog2(FADE_N) : 1;

    // output gain of 0.8 as 52429/65536
    localparam int SCALE_NUM   = 52429;
    localparam int SCALE_SHIFT = 16;

    localparam int ACC_W   = SAMPLE_W + COEF_W + IDX_W + 2;
    localparam int T_W     = SAMPLE_W + 2;
    localparam int MUL_A_W = T_W;
    localparam int MUL_B_W = SCALE_SHIFT + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TAP_COUNT     = 2'd0,
        REG_EFFECT_ENABLE = 2'd1
    } cfg_reg_t;

    typedef logic [COEF_W-1:0] fade_rom_t [FADE_N];

    function automatic fade_rom_t build_fade();
        fade_rom_t rom;
        for (int i = 0; i < FADE_N; i++) begin
            rom[i] = COEF_W'((COEF_FLAT * (FADE_N - i)) / FADE_N);
        end
        return rom;
    endfunction

    localparam fade_rom_t FADE_ROM = build_fade();

    // flat, then the fade table, then zero
    function automatic logic [COEF_W-1:0] coef_at(logic [IDX_W-1:0] k);
        logic [COEF_W-1:0] c;
        if (int'(k) < FLAT_END) begin
            c = COEF_W'(COEF_FLAT);
        end else if (int'(k) < FADE_END) begin
            c = FADE_ROM[FADE_IW'(int'(k) - FLAT_END)];
        end else begin
            c = '0;
        end
        return c;
    endfunction

endpackage

// ----- rtl/sfir_mul.sv -----
// ----------------------------------------------------------------------------
// sfir_mul - shared registered multiplier
// Signed multiply with the product registered; used for every tap and for
// the final gain step.
// ----------------------------------------------------------------------------
module sfir_mul
    import sfir_pkg::*;
(
    input  logic                      aclk,
    input  logic signed [MUL_A_W-1:0] mul_a,
    input  logic signed [MUL_B_W-1:0] mul_b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

// ----- rtl/stereo_fir_lowpass_muffle.sv -----
// ----------------------------------------------------------------------------
// stereo_fir_lowpass_muffle - stereo low-pass FIR muffle
// Per-channel delay line, one multiply-accumulate per tap, gain of 0.8 and
// saturation; bypass passes words through unchanged.
// ----------------------------------------------------------------------------
// Filtering: the word runs through states TAPS, DRAIN, ROUND, SCALE, SAT, FINISH;
//   the next word is taken once the result is loaded into the output register (one
//   tap per cycle through the single shared multiplier and the delay memory read port).
// Bypass: the word goes via result_reg to the output register, one word at a time.
// Reset (synchronous, active low) clears control, registers and fill counts;
//   history not yet written reads as zero through the fill counts, no sweep.
// ----------------------------------------------------------------------------
module stereo_fir_lowpass_muffle
    import sfir_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] sample_in
    input  logic                  s_tuser,   // [0] channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [31:0] sample_out
    output logic                  m_tuser,   // [0] channel_out
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAPS,
        ST_DRAIN,
        ST_ROUND,
        ST_SCALE,
        ST_SAT,
        ST_FINISH
    } state_t;

    state_t                   state_reg;
    logic [TAP_CFG_W-1:0]     tap_count_reg;
    logic                     effect_enable_reg;
    logic [IDX_W-1:0]         pos_reg [2];
    logic [TAPS_W-1:0]        fill_reg [2];
    logic [TAPS_W-1:0]        fill_cur_reg;
    logic                     ch_reg;
    logic [IDX_W-1:0]         k_reg;
    logic [IDX_W-1:0]         last_reg;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic                     v1_reg;
    logic                     v2_reg;
    logic [COEF_W-1:0]        coef_reg;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [T_W-1:0]    t_reg;
    logic [31:0]              result_reg;
    logic                     m_tvalid_reg;
    logic [31:0]              m_tdata_reg;
    logic                     m_tuser_reg;

    logic [SAMPLE_W-1:0]      dl_mem [2][MAX_TAPS];

    logic                     in_acc;
    logic                     in_ch;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [TAPS_W-1:0]        taps_eff;
    logic [IDX_W-1:0]         last_next;
    logic [IDX_W-1:0]         pos_cur;
    logic [IDX_W-1:0]         pos_next;
    logic [TAPS_W-1:0]        fill_next;
    logic [IDX_W-1:0]         rd_idx_next;
    logic                     tap_ok;
    logic                     start_filter;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic signed [ACC_W-1:0]  acc_bias;
    logic signed [ACC_W-1:0]  t_full;
    logic [ACC_W-T_W:0]       t_top;
    logic signed [T_W-1:0]    t_clamp;
    logic signed [PROD_W-1:0] y_bias;
    logic signed [PROD_W-1:0] y_full;
    logic [PROD_W-SAMPLE_W:0] y_top;
    logic signed [SAMPLE_W-1:0] y_sat;

    assign s_tready     = (state_reg == ST_IDLE);
    assign in_acc       = s_tvalid && s_tready;
    assign in_ch        = s_tuser;
    assign in_sample    = s_tdata[SAMPLE_W-1:0];
    assign start_filter = in_acc && effect_enable_reg;

    always_comb begin
        if (tap_count_reg == '0) begin
            taps_eff = TAPS_W'(1);
        end else if (32'(tap_count_reg) > 32'(MAX_TAPS)) begin
            taps_eff = TAPS_W'(MAX_TAPS);
        end else begin
            taps_eff = TAPS_W'(tap_count_reg);
        end
    end

    assign last_next   = IDX_W'(taps_eff - TAPS_W'(1));
    assign pos_cur     = pos_reg[in_ch];
    assign pos_next    = (pos_cur == IDX_W'(MAX_TAPS - 1)) ? '0 : pos_cur + IDX_W'(1);
    assign fill_next   = (fill_reg[in_ch] == TAPS_W'(MAX_TAPS)) ? fill_reg[in_ch]
                                                                : fill_reg[in_ch] + TAPS_W'(1);
    assign rd_idx_next = (rd_idx_reg == '0) ? IDX_W'(MAX_TAPS - 1) : rd_idx_reg - IDX_W'(1);
    // taps older than the channel's history count read as zero
    assign tap_ok      = TAPS_W'(k_reg) < fill_cur_reg;

    // control and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            tap_count_reg     <= TAP_CFG_W'(1);
            effect_enable_reg <= 1'b0;
            pos_reg[0]        <= '0;
            pos_reg[1]        <= '0;
            fill_reg[0]       <= '0;
            fill_reg[1]       <= '0;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_we && cfg_addr == REG_TAP_COUNT) begin
                tap_count_reg <= cfg_wdata[TAP_CFG_W-1:0];
            end
            if (cfg_we && cfg_addr == REG_EFFECT_ENABLE) begin
                effect_enable_reg <= cfg_wdata[0];
            end

            v1_reg <= (state_reg == ST_TAPS);
            v2_reg <= v1_reg;

            if (m_tvalid_reg && m_tready && state_reg != ST_FINISH) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        ch_reg <= in_ch;
                        if (effect_enable_reg) begin
                            pos_reg[in_ch]  <= pos_next;
                            fill_reg[in_ch] <= fill_next;
                            fill_cur_reg    <= fill_next;
                            rd_idx_reg      <= pos_cur;
                            k_reg           <= '0;
                            last_reg        <= last_next;
                            state_reg       <= ST_TAPS;
                        end else begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_TAPS: begin
                    rd_idx_reg <= rd_idx_next;
                    k_reg      <= k_reg + IDX_W'(1);
                    if (k_reg == last_reg) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (!v1_reg && !v2_reg) begin
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    state_reg <= ST_SAT;
                end
                ST_SAT: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= result_reg;
                        m_tuser_reg  <= ch_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // delay memory: write newest word on entry, one tap read a cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && start_filter) begin
            dl_mem[in_ch][pos_cur] <= in_sample;
        end
        rd_data_reg <= dl_mem[ch_reg][rd_idx_reg];
    end

    // shared multiplier: taps, then the output gain
    always_comb begin
        if (state_reg == ST_SCALE) begin
            mul_a = t_reg;
            mul_b = MUL_B_W'(SCALE_NUM);
        end else begin
            mul_a = MUL_A_W'(rd_data_reg);
            mul_b = MUL_B_W'(coef_reg);
        end
    end

    sfir_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    // drop the Q0.20 fraction toward zero, then clamp; anything clamped
    // saturates after the gain anyway
    always_comb begin
        acc_bias = acc_reg;
        if (acc_reg[ACC_W-1]) begin
            acc_bias = acc_reg + ACC_W'((1 << COEF_FRAC) - 1);
        end
        t_full = acc_bias >>> COEF_FRAC;
        t_top  = t_full[ACC_W-1:T_W-1];
        if ((&t_top) || !(|t_top)) begin
            t_clamp = t_full[T_W-1:0];
        end else begin
            t_clamp = {t_full[ACC_W-1], {(T_W-1){~t_full[ACC_W-1]}}};
        end
    end

    always_comb begin
        y_bias = prod;
        if (prod[PROD_W-1]) begin
            y_bias = prod + PROD_W'((1 << SCALE_SHIFT) - 1);
        end
        y_full = y_bias >>> SCALE_SHIFT;
        y_top  = y_full[PROD_W-1:SAMPLE_W-1];
        if ((&y_top) || !(|y_top)) begin
            y_sat = y_full[SAMPLE_W-1:0];
        end else begin
            y_sat = {y_full[PROD_W-1], {(SAMPLE_W-1){~y_full[PROD_W-1]}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_TAPS) begin
            coef_reg <= tap_ok ? coef_at(k_reg) : '0;
        end

        if (state_reg == ST_IDLE && start_filter) begin
            acc_reg <= '0;
        end else if (v2_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod);
        end

        if (state_reg == ST_ROUND) begin
            t_reg <= t_clamp;
        end

        if (state_reg == ST_IDLE && in_acc && !effect_enable_reg) begin
            result_reg <= 32'(in_sample);
        end else if (state_reg == ST_SAT) begin
            result_reg <= 32'(y_sat);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // products only land in the accumulator during the tap and drain states
    a_acc_window: assert property (@(posedge aclk) disable iff (!aresetn)
        v2_reg |-> (state_reg == ST_TAPS || state_reg == ST_DRAIN))
        else $error("product valid outside tap phase");

    a_start_taps: assert property (@(posedge aclk) disable iff (!aresetn)
        start_filter |=> (state_reg == ST_TAPS))
        else $error("filtered word did not start the tap run");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg[0] <= TAPS_W'(MAX_TAPS)) && (fill_reg[1] <= TAPS_W'(MAX_TAPS)))
        else $error("history count beyond delay line depth");

    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && (!m_tvalid || m_tready)) |=> (m_tvalid && s_tready))
        else $error("finished word not presented");

endmodule

// ----- bench/sfir_muffle_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfir_muffle_checker - result prediction and comparison for the FIR muffle
// Follows the register port and both streams, keeps its own copy of the
// per-channel history and settings, and checks every result word in order.
// ----------------------------------------------------------------------------
module sfir_muffle_checker
    import sfir_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] sample_in
    input  logic                  s_tuser,   // [0] channel
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,   // [31:0] sample_out
    input  logic                  m_tuser,   // [0] channel_out
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    outstanding,
    output int                    mismatches
);

    localparam int     FLAT_GAIN  = 20971;
    localparam int     FADE_START = (MAX_TAPS * 55) / 100;
    localparam int     FADE_STOP  = (MAX_TAPS * 64) / 100;
    localparam longint Q20_ONE    = 64'sd1048576;
    localparam longint GAIN_NUM   = 64'sd52429;
    localparam longint GAIN_DEN   = 64'sd65536;
    localparam longint OUT_MAX    = 64'sd2147483647;
    localparam longint OUT_MIN    = -64'sd2147483648;

    typedef struct packed {
        logic [31:0] sample;
        logic        channel;
    } muffled_t;

    muffled_t             muffled_q [$];
    logic signed [31:0]   history [2][MAX_TAPS];
    int                   head [2];
    int unsigned          gain [MAX_TAPS];
    logic [TAP_CFG_W-1:0] tap_setting;
    logic                 muffle_on;
    int                   bad_count;

    // filtered (or bypassed) word for one input sample; advances the history
    function automatic muffled_t muffle(input logic [31:0] x, input logic ch);
        muffled_t r;
        longint   acc;
        longint   t;
        longint   y;
        int       n;
        int       p;
        r.channel = ch;
        if (!muffle_on) begin
            r.sample = x;
            return r;
        end
        if (tap_setting == 0) begin
            n = 1;
        end else if (int'(tap_setting) > MAX_TAPS) begin
            n = MAX_TAPS;
        end else begin
            n = int'(tap_setting);
        end
        p = head[ch];
        history[ch][p] = x;
        acc = 0;
        for (int k = 0; k < n; k++) begin
            acc += longint'(gain[k]) * longint'(history[ch][(p - k + MAX_TAPS) % MAX_TAPS]);
        end
        head[ch] = (p + 1) % MAX_TAPS;
        // both divisions truncate toward zero
        t = acc / Q20_ONE;
        y = (t * GAIN_NUM) / GAIN_DEN;
        if (y > OUT_MAX) begin
            y = OUT_MAX;
        end else if (y < OUT_MIN) begin
            y = OUT_MIN;
        end
        r.sample = y[31:0];
        return r;
    endfunction

    always @(posedge aclk) begin : track
        muffled_t want;
        muffled_t got;
        if (!aresetn) begin
            muffled_q.delete();
            for (int c = 0; c < 2; c++) begin
                head[c] = 0;
                for (int i = 0; i < MAX_TAPS; i++) begin
                    history[c][i] = '0;
                end
            end
            // flat, linear fade, then silence
            for (int i = 0; i < MAX_TAPS; i++) begin
                if (i < FADE_START) begin
                    gain[i] = FLAT_GAIN;
                end else if (i < FADE_STOP) begin
                    gain[i] = (FLAT_GAIN * (FADE_STOP - i)) / (FADE_STOP - FADE_START);
                end else begin
                    gain[i] = 0;
                end
            end
            tap_setting = 10'd1;
            muffle_on   = 1'b0;
            bad_count   = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_TAP_COUNT:     tap_setting = cfg_wdata[TAP_CFG_W-1:0];
                    REG_EFFECT_ENABLE: muffle_on = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata, m_tuser};
                if (muffled_q.size() == 0) begin
                    bad_count++;
                    if (bad_count <= 10) begin
                        $display("unexpected word: sample %h ch %0d", got.sample, got.channel);
                    end
                end else begin
                    want = muffled_q.pop_front();
                    if (want.sample !== got.sample || want.channel !== got.channel) begin
                        bad_count++;
                        if (bad_count <= 10) begin
                            $display("mismatch: expected sample %h ch %0d, got sample %h ch %0d",
                                     want.sample, want.channel, got.sample, got.channel);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                muffled_q.push_back(muffle(s_tdata, s_tuser));
            end
        end
        outstanding <= muffled_q.size();
        mismatches  <= bad_count;
    end

endmodule

// ----- bench/tb_stereo_fir_lowpass_muffle.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_stereo_fir_lowpass_muffle - stimulus and verdict for the FIR muffle
// Directed words at the sample and register extremes, then phases of random
// words over a range of tap counts, with idle and stall patterns on both
// streams. Prediction and comparison live in the checker beside the block.
// ----------------------------------------------------------------------------
module tb_stereo_fir_lowpass_muffle;
    import sfir_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 64;
    localparam int RANDOM_PHASES  = 16;

    // indexes with no register behind them
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_HI = 2'd3;

    typedef enum int {MIX_FULL, MIX_LOUD, MIX_QUIET, MIX_EDGE} mix_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata   = '0;   // [31:0] sample_in
    logic                  s_tuser   = 1'b0; // [0] channel
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;          // [31:0] sample_out
    logic                  m_tuser;          // [0] channel_out
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int outstanding;
    int mismatches;
    int quiet_cycles = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    stereo_fir_lowpass_muffle i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    sfir_muffle_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // hold the sender off until every word in flight has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_word(input logic [31:0] x, input logic ch);
        while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        s_tuser  <= ch;
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic logic [31:0] make_sample(input mix_t mix, input logic ch);
        logic [31:0] v;
        case (mix)
            MIX_LOUD: begin
                // left pinned high, right pinned low, to drive the sum into clipping
                if ($urandom_range(0, 15) == 0) begin
                    v = $urandom;
                end else if (ch == 1'b0) begin
                    v = 32'h7FFF_FFFF - $urandom_range(0, 255);
                end else begin
                    v = 32'h8000_0000 + $urandom_range(0, 255);
                end
            end
            MIX_QUIET: v = $urandom_range(0, 2000) - 32'd1000;
            MIX_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       v = 32'h0000_0000;
                    1:       v = 32'h0000_0001;
                    2:       v = 32'hFFFF_FFFF;
                    3:       v = 32'h7FFF_FFFF;
                    default: v = 32'h8000_0000;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic pick_phase(input int ph, output int taps, output logic en,
                              output int count, output mix_t mix);
        en = 1'b1;
        case (ph)
            0:  begin taps = 5;    count = 50;  mix = MIX_FULL;  end
            1:  begin taps = 1;    count = 60;  mix = MIX_FULL;  en = 1'b0; end
            2:  begin taps = 16;   count = 80;  mix = MIX_QUIET; end
            // cheap fill of loud history, then the long filter sees it at once
            3:  begin taps = 1;    count = 180; mix = MIX_LOUD;  end
            4:  begin taps = 512;  count = 24;  mix = MIX_LOUD;  end
            5:  begin taps = 0;    count = 60;  mix = MIX_EDGE;  end
            6:  begin taps = 33;   count = 40;  mix = MIX_FULL;  end
            7:  begin taps = 1023; count = 20;  mix = MIX_FULL;  end
            8:  begin taps = 2;    count = 80;  mix = MIX_FULL;  end
            9:  begin taps = 600;  count = 60;  mix = MIX_FULL;  en = 1'b0; end
            10: begin taps = 8;    count = 80;  mix = MIX_EDGE;  end
            11: begin taps = 300;  count = 24;  mix = MIX_LOUD;  end
            12: begin taps = 3;    count = 40;  mix = MIX_FULL;  end
            13: begin taps = 513;  count = 20;  mix = MIX_QUIET; end
            14: begin taps = 64;   count = 50;  mix = MIX_LOUD;  end
            default: begin
                taps  = $urandom_range(1, 40);
                count = 60;
                mix   = MIX_FULL;
            end
        endcase
    endtask

    initial begin
        int                    taps;
        int                    count;
        logic                  en;
        logic                  ch;
        mix_t                  mix;
        logic [CFG_DATA_W-1:0] wval;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: bypass, one tap
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);

        write_reg(REG_EFFECT_ENABLE, 10'd1);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);

        // zero taps behaves as one
        write_reg(REG_TAP_COUNT, 10'd0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_3039, 1'b0);

        // writes to missing registers must change nothing; 1023 clamps to 512
        write_reg(REG_SPARE_LO, 10'h3FF);
        write_reg(REG_SPARE_HI, 10'h000);
        write_reg(REG_TAP_COUNT, 10'h3FF);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b0);

        write_reg(REG_TAP_COUNT, 10'd512);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b1);

        write_reg(REG_TAP_COUNT, 10'd2);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);

        // only bit 0 counts: this disables the filter
        write_reg(REG_EFFECT_ENABLE, 10'h3FE);
        send_word(32'h1234_5678, 1'b1);
        send_word(32'h8000_0000, 1'b0);

        write_reg(REG_EFFECT_ENABLE, 10'd1);
        write_reg(REG_TAP_COUNT, 10'd511);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            pick_phase(ph, taps, en, count, mix);
            write_reg(REG_TAP_COUNT, CFG_DATA_W'(taps));
            wval    = CFG_DATA_W'($urandom);
            wval[0] = en;
            write_reg(REG_EFFECT_ENABLE, wval);
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                          CFG_DATA_W'($urandom));
            end
            case (ph % 4)
                0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1:       begin tx_idle_pct = 76; rx_stall_pct = 0;  end
                2:       begin tx_idle_pct = 0;  rx_stall_pct = 76; end
                default: begin tx_idle_pct = 38; rx_stall_pct = 38; end
            endcase
            for (int n = 0; n < count; n++) begin
                ch = 1'($urandom_range(0, 1));
                send_word(make_sample(mix, ch), ch);
                if ($urandom_range(0, 39) == 0) begin
                    wait_for_results();
                end
            end
        end

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/sfir_pkg.sv
rtl/sfir_mul.sv
rtl/stereo_fir_lowpass_muffle.sv
bench/sfir_muffle_checker.sv
bench/tb_stereo_fir_lowpass_muffle.sv
